// ----- hdl/rdsc_pkg.sv -----
package rdsc_pkg;

    localparam int VALUE_W = 32;
    localparam int RADIX_W = 5;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 7;
    // Wide enough for a slot ring of up to eight slots, that is DIGITS up to 111.
    localparam int TAG_W   = 3;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd2;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0]  CHAR_A      = 7'h61;

    // Register index, taken from paddr[2].
    localparam logic REG_RADIX = 1'b0;

    // One bit of the value on its way into the divider array.
    typedef struct packed {
        logic             valid;
        logic             dbit;
        logic             first;
        logic             last;
        logic [TAG_W-1:0] tag;
    } t_beat;

    // A finished digit from one divider cell.
    typedef struct packed {
        logic               en;
        logic [TAG_W-1:0]   tag;
        logic [DIGIT_W-1:0] digit;
    } t_dig_wr;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] v);
        logic [RADIX_W-1:0] r;
        if (v < RADIX_MIN) begin
            r = RADIX_MIN;
        end else if (v > RADIX_MAX) begin
            r = RADIX_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_A + CHAR_W'(d - 4'd10);
        end
        return c;
    endfunction

endpackage

// ----- hdl/rdsc_front.sv -----
module rdsc_front
    import rdsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_slot_free,
    input  logic [TAG_W-1:0]   i_tag,
    output logic               o_alloc,
    output t_beat              o_beat
);

    localparam int CNT_W = $clog2(VALUE_W + 1);

    logic [VALUE_W-1:0] r_sh, n_sh;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [TAG_W-1:0]   r_tag, n_tag;

    // A new value may load while the final bit of the previous one goes out.
    assign o_ready = (r_cnt <= CNT_W'(1)) && i_slot_free;
    assign o_alloc = i_valid && o_ready;

    always_comb begin
        o_beat.valid = (r_cnt != '0);
        o_beat.dbit  = r_sh[VALUE_W-1];
        o_beat.first = (r_cnt == CNT_W'(VALUE_W));
        o_beat.last  = (r_cnt == CNT_W'(1));
        o_beat.tag   = r_tag;
    end

    always_comb begin
        n_sh  = r_sh;
        n_cnt = r_cnt;
        n_tag = r_tag;
        if (o_alloc) begin
            n_sh  = i_value;
            n_cnt = CNT_W'(VALUE_W);
            n_tag = i_tag;
        end else if (r_cnt != '0) begin
            n_sh  = {r_sh[VALUE_W-2:0], 1'b0};
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_sh  <= n_sh;
        r_tag <= n_tag;
    end

endmodule

// ----- hdl/rdsc_divarray.sv -----
module rdsc_divarray
    import rdsc_pkg::*;
#(
    parameter int DIGITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [RADIX_W-1:0] i_radix,
    input  t_beat              i_beat,
    output t_dig_wr            o_wr [DIGITS]
);

    // Cell g divides the quotient bit stream of cell g-1 by the radix, one
    // bit per cycle, MSB first; its remainder after the last bit is digit g.
    t_beat r_beat [DIGITS-1];

    for (genvar g = 0; g < DIGITS; g++) begin : g_cell
        t_beat              w_in;
        logic [DIGIT_W-1:0] r_rem;
        logic [RADIX_W-1:0] w_t;
        logic [RADIX_W-1:0] w_r;
        logic               w_ge;

        if (g == 0) begin : g_head
            assign w_in = i_beat;
        end else begin : g_link
            assign w_in = r_beat[g-1];
        end

        always_comb begin
            w_t  = {(w_in.first ? {DIGIT_W{1'b0}} : r_rem), w_in.dbit};
            w_ge = (w_t >= i_radix);
            w_r  = w_ge ? (w_t - i_radix) : w_t;
        end

        always_ff @(posedge i_clk) begin
            if (w_in.valid) begin
                r_rem <= w_r[DIGIT_W-1:0];
            end
        end

        assign o_wr[g] = '{en: w_in.valid && w_in.last, tag: w_in.tag,
                           digit: w_r[DIGIT_W-1:0]};

        if (g < DIGITS - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_beat[g] <= '0;
                end else begin
                    r_beat[g] <= '{valid: w_in.valid, dbit: w_ge, first: w_in.first,
                                   last: w_in.last, tag: w_in.tag};
                end
            end
        end
    end

endmodule

// ----- hdl/rdsc_back.sv -----
module rdsc_back
    import rdsc_pkg::*;
#(
    parameter int DIGITS = 32,
    parameter int NSLOT  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_alloc,
    output logic              o_slot_free,
    output logic [TAG_W-1:0]  o_tag,
    input  t_dig_wr           i_wr [DIGITS],
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CHAR_W-1:0] o_char,
    output logic              o_last
);

    localparam int SLOT_W = $clog2(NSLOT);
    localparam int USED_W = $clog2(NSLOT + 1);
    localparam int ECNT_W = $clog2(DIGITS);

    // Each slot is a shift line of digits, most significant at the top.
    logic [DIGIT_W-1:0] r_slot [NSLOT][DIGITS];
    logic [NSLOT-1:0]   r_full, n_full;
    logic [SLOT_W-1:0]  r_wslot, n_wslot;
    logic [SLOT_W-1:0]  r_rslot, n_rslot;
    logic [USED_W-1:0]  r_used, n_used;
    logic [ECNT_W-1:0]  r_ecnt, n_ecnt;
    logic               w_pop;
    logic               w_done;
    logic [SLOT_W-1:0]  w_dtag;

    assign o_slot_free = (r_used != USED_W'(NSLOT));
    assign o_tag       = TAG_W'(r_wslot);
    assign o_valid     = r_full[r_rslot];
    assign o_char      = glyph(r_slot[r_rslot][DIGITS-1]);
    assign o_last      = (r_ecnt == ECNT_W'(DIGITS - 1));
    assign w_pop       = o_valid && i_ready;
    assign w_done      = w_pop && o_last;
    assign w_dtag      = i_wr[DIGITS-1].tag[SLOT_W-1:0];

    always_comb begin
        n_full  = r_full;
        n_wslot = r_wslot;
        n_rslot = r_rslot;
        n_used  = r_used;
        n_ecnt  = r_ecnt;
        if (i_wr[DIGITS-1].en) begin
            n_full[w_dtag] = 1'b1;
        end
        if (w_pop) begin
            n_ecnt = r_ecnt + ECNT_W'(1);
        end
        if (w_done) begin
            n_full[r_rslot] = 1'b0;
            n_ecnt          = '0;
            n_rslot = (r_rslot == SLOT_W'(NSLOT - 1)) ? '0 : r_rslot + SLOT_W'(1);
        end
        if (i_alloc) begin
            n_wslot = (r_wslot == SLOT_W'(NSLOT - 1)) ? '0 : r_wslot + SLOT_W'(1);
        end
        n_used = r_used + USED_W'(i_alloc) - USED_W'(w_done);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full  <= '0;
            r_wslot <= '0;
            r_rslot <= '0;
            r_used  <= '0;
            r_ecnt  <= '0;
        end else begin
            r_full  <= n_full;
            r_wslot <= n_wslot;
            r_rslot <= n_rslot;
            r_used  <= n_used;
            r_ecnt  <= n_ecnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NSLOT; s++) begin
            for (int j = 0; j < DIGITS; j++) begin
                if (w_pop && (r_rslot == SLOT_W'(s)) && (j > 0)) begin
                    r_slot[s][j] <= r_slot[s][j-1];
                end else if (i_wr[j].en && (i_wr[j].tag[SLOT_W-1:0] == SLOT_W'(s))) begin
                    r_slot[s][j] <= i_wr[j].digit;
                end
            end
        end
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(NSLOT))
        else $error("slot count exceeds the ring size");

    a_fill_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr[DIGITS-1].en |-> !r_full[w_dtag])
        else $error("digits completed into a slot that is still full");

    a_valid_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_used != '0))
        else $error("output valid with no reserved slot");

    a_ring_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> (r_rslot != $past(r_rslot)) && (r_ecnt == '0))
        else $error("read slot did not advance after the last beat");

endmodule

// ----- hdl/radix_digit_string_converter.sv -----
// Converts each 32-bit unsigned input beat into DIGITS lower-case ASCII digit
// beats in the base held in the radix register (2 to 16, clamped on write),
// most significant digit first, zero padded, with tlast on the final beat. The
// value enters a chain of DIGITS divider cells one bit per cycle, and a new
// input beat is taken no earlier than while the final bit of the previous one
// goes out, and only when a slot is free. The finished digits wait in a ring
// of DIGITS/16 + 2 slots; each item sends DIGITS output beats.
module radix_digit_string_converter
    import rdsc_pkg::*;
#(
    parameter int DIGITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] digit_char, [7] zero
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NSLOT = DIGITS / 16 + 2;

    logic [RADIX_W-1:0] r_radix;
    logic               w_slot_free;
    logic [TAG_W-1:0]   w_tag;
    logic               w_alloc;
    t_beat              w_beat;
    t_dig_wr            w_wr [DIGITS];
    logic [CHAR_W-1:0]  w_char;

    assign pready = 1'b1;
    assign prdata = {{(32 - RADIX_W){1'b0}}, r_radix};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_RADIX)) begin
            r_radix <= clamp_radix(pwdata[RADIX_W-1:0]);
        end
    end

    rdsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_value     (s_axis_tdata),
        .i_slot_free (w_slot_free),
        .i_tag       (w_tag),
        .o_alloc     (w_alloc),
        .o_beat      (w_beat)
    );

    rdsc_divarray #(
        .DIGITS (DIGITS)
    ) u_divarray (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_radix (r_radix),
        .i_beat  (w_beat),
        .o_wr    (w_wr)
    );

    rdsc_back #(
        .DIGITS (DIGITS),
        .NSLOT  (NSLOT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_alloc     (w_alloc),
        .o_slot_free (w_slot_free),
        .o_tag       (w_tag),
        .i_wr        (w_wr),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_char      (w_char),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, w_char};

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
    import rdsc_pkg::*;

    localparam int DIGITS         = 32;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 100;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_ITEMS    = 22;

    localparam logic [2:0] ADDR_RADIX  = {REG_RADIX, 2'b00};
    localparam logic [2:0] ADDR_UNUSED = {~REG_RADIX, 2'b00};

    localparam logic [8*16-1:0] GLYPHS = "0123456789abcdef";
    localparam logic [127:0] ZERO16 = {"00000000", "00000000"};
    localparam logic [8*DIGITS-1:0] ALL_ZERO = {ZERO16, ZERO16};
    localparam logic [8*DIGITS-1:0] ALL_ONE =
        {"11111111", "11111111", "11111111", "11111111"};

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_char_beat;

    typedef struct packed {
        logic                cfg;
        logic [2:0]          addr;
        logic [31:0]         wdata;
        logic [31:0]         value;
        logic                typed;
        logic [8*DIGITS-1:0] want;
    } t_dir_row;

    localparam int DIR_COUNT = 22;
    localparam t_dir_row DIR_ROWS [DIR_COUNT] = '{
        // Radix 2 straight out of reset.
        '{1'b0, ADDR_RADIX, 32'd0, 32'h0000_0000, 1'b1, ALL_ZERO},
        '{1'b0, ADDR_RADIX, 32'd0, 32'hFFFF_FFFF, 1'b1, ALL_ONE},
        '{1'b0, ADDR_RADIX, 32'd0, 32'h8000_0000, 1'b1,
            {"10000000", "00000000", ZERO16}},
        '{1'b0, ADDR_RADIX, 32'd0, 32'h0000_0001, 1'b1, {ZERO16, "00000000", "00000001"}},
        '{1'b0, ADDR_RADIX, 32'd0, 32'h5A5A_5A5A, 1'b0, ALL_ZERO},
        '{1'b1, ADDR_RADIX, 32'd16, 32'hFFFF_FFFF, 1'b1, {ZERO16, "00000000", "ffffffff"}},
        '{1'b0, ADDR_RADIX, 32'd0, 32'h0123_4567, 1'b1, {ZERO16, "00000000", "01234567"}},
        '{1'b0, ADDR_RADIX, 32'd0, 32'h89AB_CDEF, 1'b1, {ZERO16, "00000000", "89abcdef"}},
        '{1'b0, ADDR_RADIX, 32'd0, 32'h0000_0000, 1'b1, ALL_ZERO},
        // Out-of-range radix writes are clamped to the nearest legal base.
        '{1'b1, ADDR_RADIX, 32'd0, 32'd5, 1'b1, {ZERO16, "00000000", "00000101"}},
        '{1'b1, ADDR_RADIX, 32'd31, 32'hDEAD_BEEF, 1'b1, {ZERO16, "00000000", "deadbeef"}},
        '{1'b1, ADDR_RADIX, 32'd1, 32'd2, 1'b1, {ZERO16, "00000000", "00000010"}},
        '{1'b1, ADDR_RADIX, 32'd17, 32'h10, 1'b1, {ZERO16, "00000000", "00000010"}},
        // Only the low five bits of the write count, so this selects base 5.
        '{1'b1, ADDR_RADIX, 32'h25, 32'hFFFF_FFFF, 1'b0, ALL_ZERO},
        // A write to the unmapped address must leave base 5 in place.
        '{1'b1, ADDR_UNUSED, 32'd3, 32'd12345, 1'b0, ALL_ZERO},
        '{1'b1, ADDR_RADIX, 32'd10, 32'hFFFF_FFFF, 1'b1, {ZERO16, "00000042", "94967295"}},
        '{1'b0, ADDR_RADIX, 32'd0, 32'd1000000000, 1'b1, {ZERO16, "00000010", "00000000"}},
        '{1'b1, ADDR_RADIX, 32'd3, 32'hFFFF_FFFF, 1'b0, ALL_ZERO},
        '{1'b1, ADDR_RADIX, 32'd7, 32'h7FFF_FFFF, 1'b0, ALL_ZERO},
        '{1'b1, ADDR_RADIX, 32'd15, 32'hFFFF_FFFF, 1'b0, ALL_ZERO},
        '{1'b1, ADDR_RADIX, 32'd11, 32'hFFFF_FFFF, 1'b0, ALL_ZERO},
        '{1'b1, ADDR_RADIX, 32'd2, 32'hAAAA_AAAA, 1'b1,
            {"10101010", "10101010", "10101010", "10101010"}}
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    t_char_beat        pending_chars[$];
    logic [RADIX_W-1:0] cur_radix     = RADIX_RESET;
    logic [16:0]        radix_seen    = '0;
    int                 src_idle_pct  = 0;
    int                 sink_stall_pct = 0;
    int                 hold_req      = 0;
    int                 hold_seen     = 0;
    int                 hold_left     = 0;
    int                 idle_cycles   = 0;
    int                 values_sent   = 0;
    int                 chars_seen    = 0;
    int                 errors        = 0;

    radix_digit_string_converter #(
        .DIGITS(DIGITS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        if (errors < 10) begin
            $display("Mismatch on %s at beat %0d: expected 0x%0h, got 0x%0h",
                     what, chars_seen, want, got);
        end
        errors++;
    endfunction

    // Queues the digit beats of one value in the current base, most significant first.
    function automatic void expand_digits(input logic [31:0] value, input logic [4:0] base);
        logic [31:0]       rest;
        logic [3:0]        dig [DIGITS];
        logic [CHAR_W-1:0] ch;
        rest = value;
        for (int k = 0; k < DIGITS; k++) begin
            dig[k] = 4'(rest % 32'(base));
            rest   = rest / 32'(base);
        end
        for (int k = 0; k < DIGITS; k++) begin
            ch = GLYPHS[8*(15 - int'(dig[DIGITS-1-k])) +: CHAR_W];
            pending_chars.push_back('{ch: ch, last: (k == DIGITS - 1)});
        end
    endfunction

    function automatic logic [31:0] pick_value(input logic [4:0] base);
        logic [63:0] pw;
        int          k;
        logic [31:0] v;
        case ($urandom_range(0, 4))
            0: v = $urandom();
            1: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h0;
                    1: v = 32'hFFFF_FFFF;
                    2: v = 32'h8000_0000;
                    default: v = 32'h1;
                endcase
            end
            2: v = $urandom() >> $urandom_range(0, 31);
            default: begin
                // Land on or just below a power of the base, where a digit rolls over.
                pw = 64'd1;
                k  = $urandom_range(1, 31);
                repeat (k) begin
                    if (pw <= 64'hFFFF_FFFF) pw = pw * base;
                end
                if (pw > 64'hFFFF_FFFF) begin
                    v = 32'hFFFF_FFFF;
                end else begin
                    v = pw[31:0] - $urandom_range(0, 1);
                end
            end
        endcase
        return v;
    endfunction

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_RADIX) begin
            if (data[4:0] < RADIX_MIN) begin
                cur_radix = RADIX_MIN;
            end else if (data[4:0] > RADIX_MAX) begin
                cur_radix = RADIX_MAX;
            end else begin
                cur_radix = data[4:0];
            end
        end
    endtask

    task automatic apb_check_radix();
        logic [31:0] got;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_RADIX;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== 32'(cur_radix)) flag_mismatch("radix readback", 32'(cur_radix), got);
    endtask

    task automatic offer_value(input logic [31:0] value, input logic typed,
                               input logic [8*DIGITS-1:0] want);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < src_idle_pct) gap++;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do @(posedge i_clk); while (!s_axis_tready);
        if (typed) begin
            for (int k = 0; k < DIGITS; k++) begin
                pending_chars.push_back('{ch: want[8*(DIGITS-1-k) +: CHAR_W],
                                          last: (k == DIGITS - 1)});
            end
        end else begin
            expand_digits(value, cur_radix);
        end
        radix_seen[cur_radix] = 1'b1;
        values_sent++;
    endtask

    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_chars.size() != 0);
    endtask

    // Output side: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
        end else if (hold_req != hold_seen) begin
            hold_seen     <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_char_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_chars.size() == 0) begin
                flag_mismatch("unexpected beat", 32'h0, {23'h0, m_axis_tlast, m_axis_tdata});
            end else begin
                want = pending_chars.pop_front();
                if (m_axis_tdata[CHAR_W-1:0] !== want.ch) begin
                    flag_mismatch("digit_char", 32'(want.ch), 32'(m_axis_tdata[CHAR_W-1:0]));
                end
                if (m_axis_tlast !== want.last) begin
                    flag_mismatch("last_digit", 32'(want.last), 32'(m_axis_tlast));
                end
                if (m_axis_tdata[7] !== 1'b0) begin
                    flag_mismatch("tdata pad bit", 32'h0, 32'(m_axis_tdata[7]));
                end
            end
            chars_seen++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no beat for %0d cycles, %0d digit beats still due",
                     idle_cycles, pending_chars.size());
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : run
        logic [4:0] raw;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        apb_check_radix();

        for (int r = 0; r < DIR_COUNT; r++) begin
            if (DIR_ROWS[r].cfg) begin
                drain_pipeline();
                apb_write(DIR_ROWS[r].addr, DIR_ROWS[r].wdata);
                apb_check_radix();
            end
            offer_value(DIR_ROWS[r].value, DIR_ROWS[r].typed, DIR_ROWS[r].want);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct <= 0;  raw = 5'd16; end
                1: begin src_idle_pct = 63; sink_stall_pct <= 0;  raw = 5'd0; end
                2: begin src_idle_pct = 0;  sink_stall_pct <= 63; raw = 5'($urandom_range(0, 31)); end
                3: begin src_idle_pct = 32; sink_stall_pct <= 32; raw = 5'($urandom_range(3, 15)); end
                default: begin
                    src_idle_pct = 0;
                    sink_stall_pct <= 0;
                    raw = 5'($urandom_range(2, 16));
                end
            endcase
            drain_pipeline();
            apb_write(ADDR_RADIX, ($urandom() & ~32'h1F) | 32'(raw));
            apb_check_radix();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Hold the output side off while input keeps coming, so the block backs up.
                if (ph == 0 && n == 3) hold_req <= hold_req + 1;
                if (ph == 1 && n == 11) drain_pipeline();
                offer_value(pick_value(cur_radix), 1'b0, ALL_ZERO);
            end
        end

        drain_pipeline();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Converted %0d values into %0d digit beats across %0d different bases.",
                 values_sent, chars_seen, $countones(radix_seen));
        $display("Included clamped and masked radix writes, an unmapped write, stalls and a long hold-off.");
        if (errors == 0 && pending_chars.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d digit beats never arrived", errors,
                     pending_chars.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/rdsc_pkg.sv
hdl/rdsc_front.sv
hdl/rdsc_divarray.sv
hdl/rdsc_back.sv
hdl/radix_digit_string_converter.sv
verif/tb_top.sv
